/* src/assert_macros.svh */
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/wams_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wams_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int COUNT_BITS       = 7;
    localparam int EDGE_BITS        = 12;

    localparam logic [EDGE_BITS-1:0]  EDGE_LIMIT   = 12'hFFF;
    localparam logic [COUNT_BITS-1:0] VCOUNT_RESET = 7'd64;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_QUERY  = 3'd1,
        OP_REMOVE = 3'd2,
        OP_NEXT   = 3'd3,
        OP_EMPTY  = 3'd4,
        OP_CLEAR  = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_SIDE = 3'b100
    } state_t;

endpackage

`default_nettype wire

/* src/weighted_adjacency_matrix_store.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Undirected weighted graph held as an adjacency matrix. Presence bits live
// in a row memory, one row of MAX_VERTICES bits per vertex, with a valid flag
// per row so that reset and the clear opcode empty the graph at once; weights
// live in a separate memory that is never cleared and is read only behind a
// set presence bit. The transfer edge reads row vertex_a and the weight entry,
// and in S_LOOK the opcode is resolved from the whole row (bit test, masked
// priority encode, or row OR) and the result register is loaded. A valid
// insert, or a remove that finds its edge, between two distinct vertices
// goes on to S_SIDE to rewrite the mirror row (and, for insert, the mirror
// weight) and load the result there, since the row memory has one read and
// one write port. The result register frees the input side: a new item is
// taken while a finished result waits, and the block stalls only when it
// must load a result while the previous one is still untaken.
module weighted_adjacency_matrix_store #(
    parameter int MAX_VERTICES = wams_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = wams_pkg::WEIGHT_BITS_DEF,
    localparam int VW          = $clog2(MAX_VERTICES)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [2:0]                     opcode,
    input  wire logic [VW-1:0]                  vertex_a,
    input  wire logic [VW-1:0]                  vertex_b,
    input  wire logic                           from_start,
    input  wire logic [WEIGHT_BITS-1:0]         weight_in,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [1:0]                          status,
    output logic                                found,
    output logic [WEIGHT_BITS-1:0]              weight_out,
    output logic [VW-1:0]                       neighbour,
    output logic [wams_pkg::EDGE_BITS-1:0]      edge_total,

    input  wire logic                           cfg_we,
    input  wire logic [wams_pkg::COUNT_BITS-1:0] cfg_wdata
);

    import wams_pkg::*;

    localparam int CW = (VW + 1 > COUNT_BITS) ? VW + 1 : COUNT_BITS;
    localparam int WA = 2 * VW;
    localparam logic [CW-1:0] MAXV = CW'(MAX_VERTICES);

    state_t                   state_reg, state_next;
    logic [COUNT_BITS-1:0]    vcount_reg;
    logic [EDGE_BITS-1:0]     edges_reg, edges_next;
    logic [MAX_VERTICES-1:0]  row_valid_reg, row_valid_next;
    logic                     out_valid_reg;

    opcode_t                  op_reg;
    logic [VW-1:0]            a_reg, b_reg;
    logic                     start_reg;
    logic [WEIGHT_BITS-1:0]   w_reg;

    logic [1:0]               status_reg;
    logic                     found_reg;
    logic [WEIGHT_BITS-1:0]   weight_reg;
    logic [VW-1:0]            nb_reg;
    logic [EDGE_BITS-1:0]     total_reg;

    logic [MAX_VERTICES-1:0]  presence_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]  row_q_reg;
    logic                     row_vq_reg;
    logic                     row_re, row_we;
    logic [VW-1:0]            row_raddr, row_waddr;
    logic [MAX_VERTICES-1:0]  row_wdata;

    logic [WEIGHT_BITS-1:0]   weight_mem [2**WA];
    logic [WEIGHT_BITS-1:0]   wt_q_reg;
    logic                     wt_we;
    logic [WA-1:0]            wt_waddr;
    logic [WEIGHT_BITS-1:0]   wt_wdata;

    logic                     accept, advance, out_load;
    logic [CW-1:0]            n_live, scan_from;
    logic                     a_ok, b_ok;
    logic [MAX_VERTICES-1:0]  row, live_mask, scan_mask, scan_bits;
    logic                     hit, scan_any, row_any;
    logic [VW-1:0]            scan_idx;

    status_t                  res_status;
    logic                     res_found;
    logic [WEIGHT_BITS-1:0]   res_weight;
    logic [VW-1:0]            res_nb;

    logic                     modify, mod_bit, wt_mod, need_side, go;
    logic                     cnt_up, cnt_down, clear_all;

    assign accept   = in_valid && in_ready;
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign found      = found_reg;
    assign weight_out = weight_reg;
    assign neighbour  = nb_reg;
    assign edge_total = total_reg;

    assign n_live    = (CW'(vcount_reg) > MAXV) ? MAXV : CW'(vcount_reg);
    assign a_ok      = CW'(a_reg) < n_live;
    assign b_ok      = CW'(b_reg) < n_live;
    assign row       = row_vq_reg ? row_q_reg : '0;
    assign hit       = row[b_reg];
    assign scan_from = start_reg ? '0 : CW'(b_reg) + CW'(1);

    always_comb
    begin
        for (int c = 0; c < MAX_VERTICES; c++)
        begin
            live_mask[c] = CW'(c) < n_live;
            scan_mask[c] = (CW'(c) < n_live) && (CW'(c) >= scan_from);
        end
    end

    assign scan_bits = row & scan_mask;
    assign scan_any  = |scan_bits;
    assign row_any   = |(row & live_mask);

    always_comb
    begin
        scan_idx = '0;
        for (int c = MAX_VERTICES - 1; c >= 0; c--)
        begin
            if (scan_bits[c])
            begin
                scan_idx = VW'(c);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        edges_next     = edges_reg;
        row_valid_next = row_valid_reg;
        row_re         = 1'b0;
        row_raddr      = vertex_a;
        row_we         = 1'b0;
        row_waddr      = a_reg;
        row_wdata      = row;
        wt_we          = 1'b0;
        wt_waddr       = {a_reg, b_reg};
        wt_wdata       = w_reg;
        out_load       = 1'b0;
        res_status     = ST_OK;
        res_found      = 1'b0;
        res_weight     = '0;
        res_nb         = '0;
        modify         = 1'b0;
        mod_bit        = 1'b0;
        wt_mod         = 1'b0;
        need_side      = 1'b0;
        go             = 1'b0;
        cnt_up         = 1'b0;
        cnt_down       = 1'b0;
        clear_all      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    row_re     = 1'b1;
                    state_next = S_LOOK;
                end
            end

            S_LOOK:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (!(a_ok && b_ok))
                        begin
                            res_status = ST_INVALID;
                        end
                        else
                        begin
                            modify    = 1'b1;
                            mod_bit   = 1'b1;
                            wt_mod    = 1'b1;
                            cnt_up    = !hit && (edges_reg != EDGE_LIMIT);
                            need_side = (a_reg != b_reg);
                        end
                    end
                    OP_QUERY, OP_REMOVE:
                    begin
                        if (!(a_ok && b_ok))
                        begin
                            res_status = ST_INVALID;
                        end
                        else if (!hit)
                        begin
                            res_status = ST_MISSING;
                        end
                        else
                        begin
                            res_found  = 1'b1;
                            res_weight = wt_q_reg;
                            if (op_reg == OP_REMOVE)
                            begin
                                modify    = 1'b1;
                                cnt_down  = (edges_reg != '0);
                                need_side = (a_reg != b_reg);
                            end
                        end
                    end
                    OP_NEXT:
                    begin
                        if (!a_ok)
                        begin
                            res_status = ST_INVALID;
                        end
                        else if (scan_any)
                        begin
                            res_found = 1'b1;
                            res_nb    = scan_idx;
                        end
                        else
                        begin
                            res_status = ST_MISSING;
                        end
                    end
                    OP_EMPTY:
                    begin
                        if (!a_ok)
                        begin
                            res_status = ST_INVALID;
                        end
                        else
                        begin
                            res_found = row_any;
                        end
                    end
                    OP_CLEAR:
                    begin
                        clear_all = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase

                go = need_side || advance;

                row_wdata[b_reg] = mod_bit;
                row_we           = modify && go;
                wt_we            = wt_mod && go;

                if (go)
                begin
                    if (cnt_up)
                    begin
                        edges_next = edges_reg + EDGE_BITS'(1);
                    end
                    if (cnt_down)
                    begin
                        edges_next = edges_reg - EDGE_BITS'(1);
                    end
                    if (clear_all)
                    begin
                        edges_next     = '0;
                        row_valid_next = '0;
                    end
                end

                if (need_side)
                begin
                    row_re     = 1'b1;
                    row_raddr  = b_reg;
                    state_next = S_SIDE;
                end
                else if (advance)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_SIDE:
            begin
                row_waddr        = b_reg;
                row_wdata[a_reg] = (op_reg == OP_INSERT);
                row_we           = advance;
                wt_waddr         = {b_reg, a_reg};
                wt_we            = advance && (op_reg == OP_INSERT);
                res_found        = (op_reg == OP_REMOVE);
                res_weight       = (op_reg == OP_REMOVE) ? wt_q_reg : '0;
                out_load         = advance;
                if (advance)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (row_we)
        begin
            row_valid_next[row_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcount_reg    <= VCOUNT_RESET;
            edges_reg     <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            edges_reg     <= edges_next;
            row_valid_reg <= row_valid_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the item for the whole operation
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode_t'(opcode);
            a_reg     <= vertex_a;
            b_reg     <= vertex_b;
            start_reg <= from_start;
            w_reg     <= weight_in;
        end
        if (out_load)
        begin
            status_reg <= res_status;
            found_reg  <= res_found;
            weight_reg <= res_weight;
            nb_reg     <= res_nb;
            total_reg  <= edges_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            presence_mem[row_waddr] <= row_wdata;
        end
        if (row_re)
        begin
            row_q_reg  <= presence_mem[row_raddr];
            row_vq_reg <= row_valid_reg[row_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wt_we)
        begin
            weight_mem[wt_waddr] <= wt_wdata;
        end
        if (accept)
        begin
            wt_q_reg <= weight_mem[{vertex_a, vertex_b}];
        end
    end

    `ASSERT_IMPLY(a_side_distinct, clk, rst_n, state_reg == S_SIDE, a_reg != b_reg)
    `ASSERT_NEXT(a_accept_look, clk, rst_n, in_valid && in_ready, state_reg == S_LOOK)
    `ASSERT_NEXT(a_clear_empties, clk, rst_n, clear_all && advance, edges_reg == '0 && row_valid_reg == '0)
    `ASSERT_NEXT(a_count_quiet, clk, rst_n, state_reg == S_IDLE, $stable(edges_reg))
    `ASSERT_IMPLY(a_load_free, clk, rst_n, out_load, !out_valid_reg || out_ready)

endmodule

`default_nettype wire
